### hw/rtl/lttt_pkg.sv
`default_nettype none

package lttt_pkg;

    // default sizes
    localparam int VEHICLES_DEF  = 1024;
    localparam int LINKS_DEF     = 256;
    localparam int TICK_BITS_DEF = 16;

    // field widths
    localparam int VID_W   = 10;
    localparam int LID_W   = 8;
    localparam int TICK_W  = 16;
    localparam int TIME_W  = 32;
    localparam int UNIT_W  = 16;
    localparam int WGT_W   = 9;
    localparam int CFG_W   = 16;

    localparam int S_DATA_W = 72;   // 66 bits of fields, padded to bytes
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 4;

    // register reset values, Q8.8 and Q1.8
    localparam logic [UNIT_W-1:0] TICK_SCALE_RST = 16'd256;
    localparam logic [WGT_W-1:0]  EMA_WEIGHT_RST = 9'd128;
    localparam logic [WGT_W-1:0]  WEIGHT_ONE     = 9'd256;
    localparam logic [7:0]        ROUND_HALF     = 8'd128;

    typedef enum logic {
        CFG_TICK_SCALE = 1'b0,
        CFG_EMA_WEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_OBSERVE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        EV_LOADED     = 3'd0,
        EV_REGISTERED = 3'd1,
        EV_FREED      = 3'd2,
        EV_MOVED      = 3'd3,
        EV_ERROR      = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VREAD,
        ST_LREAD,
        ST_FOLD,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/link_travel_time_tracker.sv
`default_nettype none

// Link travel time tracker. Keeps a vehicle table (valid, current link, entry tick)
// and a link table of smoothed travel times in unsigned Q24.8 seconds, both in
// single-port style synchronous memories with registered reads. A load item
// writes a link's time; an observe item registers an unknown vehicle, or, for a known
// vehicle that finished or changed link, folds (elapsed ticks * tick scale, saturated
// to 32 bits) into the old link's time with new = (old*(256-w) + w*sample + 128) >> 8.
// Every item gives exactly one result item. Items are handled one at a time;
// a load, registration or error passes the block through accept, decode and result;
// a fold passes it through accept with vehicle read, decode with link read, two 32x9
// products, sum and write back, and result. The next item is taken in the cycle after
// the result is loaded; while the output register holds a result that is not yet
// taken, the block waits in its result state. After reset a clearing pass walks the
// vehicle table, one entry a cycle; no item is accepted until it is done. Config
// writes are taken at any time but should only be made while the block is idle.
// Averaging into a link that was never loaded returns an undefined time.
module link_travel_time_tracker #(
    parameter int VEHICLES  = lttt_pkg::VEHICLES_DEF,
    parameter int LINKS     = lttt_pkg::LINKS_DEF,
    parameter int TICK_BITS = lttt_pkg::TICK_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // vehicle_id[9:0], link_id[17:10], tick[33:18], load_value[65:34], zeros above
    input  wire logic [lttt_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // op[0]
    input  wire logic [0:0]                    i_s_axis_tuser,
    // finished
    input  wire logic                          i_s_axis_tlast,
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // updated_link[7:0], travel_time[39:8]
    output logic [lttt_pkg::M_DATA_W-1:0]      o_m_axis_tdata,
    // event_res[2:0], updated[3]
    output logic [lttt_pkg::M_USER_W-1:0]      o_m_axis_tuser,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [lttt_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int VidW  = $clog2(VEHICLES);
    localparam int LidW  = $clog2(LINKS);
    localparam int ProdW = TICK_BITS + lttt_pkg::UNIT_W;
    localparam int MulW  = lttt_pkg::TIME_W + lttt_pkg::WGT_W;
    localparam int SumW  = MulW + 1;

    typedef struct packed {
        logic                 valid;
        logic [LidW-1:0]      link;
        logic [TICK_BITS-1:0] tick;
    } t_vent;

    // control state
    lttt_pkg::t_state r_state, n_state;
    logic [VidW-1:0]  r_clr_cnt;
    logic             r_out_valid;
    logic [lttt_pkg::UNIT_W-1:0] r_tick_scale;
    logic [lttt_pkg::WGT_W-1:0]  r_ema_weight;

    // captured item
    logic                        r_op;
    logic                        r_fin;
    logic [VidW-1:0]             r_vidx;
    logic [LidW-1:0]             r_lidx;
    logic [lttt_pkg::LID_W-1:0]  r_link_raw;
    logic [TICK_BITS-1:0]        r_tick;
    logic [lttt_pkg::TIME_W-1:0] r_load_value;
    logic                        r_vid_bad;
    logic                        r_lk_bad;

    // memories and their read registers
    t_vent                       r_vmem [VEHICLES];
    logic [lttt_pkg::TIME_W-1:0] r_lmem [LINKS];
    t_vent                       r_vrd;
    logic [lttt_pkg::TIME_W-1:0] r_lrd;

    // fold datapath
    logic [lttt_pkg::TIME_W-1:0] r_sample;
    logic [MulW-1:0]             r_p_old;
    logic [MulW-1:0]             r_p_new;

    // pending result and output register
    lttt_pkg::t_event            r_ev, n_ev;
    logic                        r_upd, n_upd;
    logic [lttt_pkg::LID_W-1:0]  r_ulk, n_ulk;
    logic [lttt_pkg::TIME_W-1:0] r_tt, n_tt;
    lttt_pkg::t_event            r_out_ev;
    logic                        r_out_upd;
    logic [lttt_pkg::LID_W-1:0]  r_out_ulk;
    logic [lttt_pkg::TIME_W-1:0] r_out_tt;

    // memory port controls
    logic                        vmem_we;
    logic [VidW-1:0]             vmem_waddr;
    t_vent                       vmem_wdata;
    logic                        lmem_we;
    logic [LidW-1:0]             lmem_waddr;
    logic [lttt_pkg::TIME_W-1:0] lmem_wdata;
    logic                        lmem_re;
    logic                        out_ld;

    logic                        s_fire;
    logic [VidW-1:0]             in_vidx;
    logic [lttt_pkg::VID_W-1:0]  in_vid;
    logic [lttt_pkg::LID_W-1:0]  in_link;
    logic [lttt_pkg::TICK_W-1:0] in_tick;

    logic [lttt_pkg::WGT_W-1:0]  wgt;
    logic [lttt_pkg::WGT_W-1:0]  wgt_inv;
    logic [TICK_BITS-1:0]        dur;
    logic [ProdW-1:0]            prod;
    logic [ProdW+31:0]           prod_x;
    logic [lttt_pkg::TIME_W-1:0] sample_sat;
    logic [SumW-1:0]             ema_sum;
    logic [lttt_pkg::TIME_W-1:0] ema_new;

    assign in_vid  = i_s_axis_tdata[9:0];
    assign in_link = i_s_axis_tdata[17:10];
    assign in_tick = i_s_axis_tdata[33:18];
    assign in_vidx = VidW'(32'(in_vid));
    assign s_fire  = i_s_axis_tvalid && o_s_axis_tready;

    // weight above one is used as one
    assign wgt     = (r_ema_weight > lttt_pkg::WEIGHT_ONE) ? lttt_pkg::WEIGHT_ONE
                                                           : r_ema_weight;
    assign wgt_inv = lttt_pkg::WEIGHT_ONE - wgt;

    // elapsed ticks wrap modulo 2^TICK_BITS; sample saturates at 32 bits
    assign dur        = r_tick - r_vrd.tick;
    assign prod       = ProdW'(dur) * ProdW'(r_tick_scale);
    assign prod_x     = (ProdW + 32)'(prod);
    assign sample_sat = (prod_x[ProdW+31:32] != '0) ? '1 : prod_x[31:0];

    assign ema_sum = SumW'(r_p_old) + SumW'(r_p_new) + SumW'(lttt_pkg::ROUND_HALF);
    assign ema_new = ema_sum[39:8];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_scale <= lttt_pkg::TICK_SCALE_RST;
            r_ema_weight <= lttt_pkg::EMA_WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (lttt_pkg::t_cfg_idx'(i_cfg_idx))
                lttt_pkg::CFG_TICK_SCALE: r_tick_scale <= i_cfg_data;
                lttt_pkg::CFG_EMA_WEIGHT: r_ema_weight <= i_cfg_data[lttt_pkg::WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lttt_pkg::ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lttt_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // next state, memory controls and result
    always_comb begin
        n_state    = r_state;
        vmem_we    = 1'b0;
        vmem_waddr = r_vidx;
        vmem_wdata = '{valid: 1'b1, link: r_lidx, tick: r_tick};
        lmem_we    = 1'b0;
        lmem_waddr = r_lidx;
        lmem_wdata = r_load_value;
        lmem_re    = 1'b0;
        out_ld     = 1'b0;
        n_ev       = r_ev;
        n_upd      = r_upd;
        n_ulk      = r_ulk;
        n_tt       = r_tt;
        o_s_axis_tready = 1'b0;

        unique case (r_state)
            lttt_pkg::ST_CLEAR: begin
                vmem_we    = 1'b1;
                vmem_waddr = r_clr_cnt;
                vmem_wdata = '0;
                if (r_clr_cnt == VidW'(VEHICLES - 1)) begin
                    n_state = lttt_pkg::ST_IDLE;
                end
            end
            lttt_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = lttt_pkg::ST_VREAD;
                end
            end
            lttt_pkg::ST_VREAD: begin
                n_state = lttt_pkg::ST_RESP;
                n_ev    = lttt_pkg::EV_ERROR;
                n_upd   = 1'b0;
                n_ulk   = '0;
                n_tt    = '0;
                priority if (r_lk_bad) begin
                    n_ev = lttt_pkg::EV_ERROR;
                end else if (r_op == lttt_pkg::OP_LOAD) begin
                    lmem_we = 1'b1;
                    n_ev    = lttt_pkg::EV_LOADED;
                    n_upd   = 1'b1;
                    n_ulk   = r_link_raw;
                    n_tt    = r_load_value;
                end else if (r_vid_bad) begin
                    n_ev = lttt_pkg::EV_ERROR;
                end else if (!r_vrd.valid) begin
                    vmem_we = 1'b1;
                    n_ev    = lttt_pkg::EV_REGISTERED;
                end else if (r_fin) begin
                    // finished wins over a link change; sample goes to the old link
                    vmem_we    = 1'b1;
                    vmem_wdata = '0;
                    lmem_re    = 1'b1;
                    n_ev       = lttt_pkg::EV_FREED;
                    n_state    = lttt_pkg::ST_LREAD;
                end else if (r_vrd.link != r_lidx) begin
                    vmem_we = 1'b1;
                    lmem_re = 1'b1;
                    n_ev    = lttt_pkg::EV_MOVED;
                    n_state = lttt_pkg::ST_LREAD;
                end else begin
                    n_ev = lttt_pkg::EV_ERROR;
                end
            end
            lttt_pkg::ST_LREAD: begin
                n_state = lttt_pkg::ST_FOLD;
            end
            lttt_pkg::ST_FOLD: begin
                lmem_we    = 1'b1;
                lmem_waddr = r_vrd.link;
                lmem_wdata = ema_new;
                n_upd      = 1'b1;
                n_ulk      = lttt_pkg::LID_W'(r_vrd.link);
                n_tt       = ema_new;
                n_state    = lttt_pkg::ST_RESP;
            end
            lttt_pkg::ST_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_ld  = 1'b1;
                    n_state = lttt_pkg::ST_IDLE;
                end
            end
            default: n_state = lttt_pkg::ST_IDLE;
        endcase
    end

    // vehicle table: read at accept, written after the decision or by the clear sweep
    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_waddr] <= vmem_wdata;
        end
        if (s_fire) begin
            r_vrd <= r_vmem[in_vidx];
        end
    end

    // link table: read the old link's time, write a load or a fold
    always_ff @(posedge i_clk) begin
        if (lmem_we) begin
            r_lmem[lmem_waddr] <= lmem_wdata;
        end
        if (lmem_re) begin
            r_lrd <= r_lmem[r_vrd.link];
        end
    end

    // item capture and fold datapath
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_op         <= i_s_axis_tuser[0];
            r_fin        <= i_s_axis_tlast;
            r_vidx       <= in_vidx;
            r_lidx       <= LidW'(32'(in_link));
            r_link_raw   <= in_link;
            r_tick       <= TICK_BITS'(32'(in_tick));
            r_load_value <= i_s_axis_tdata[65:34];
            r_vid_bad    <= 32'(in_vid) >= VEHICLES;
            r_lk_bad     <= 32'(in_link) >= LINKS;
        end
        if (r_state == lttt_pkg::ST_VREAD) begin
            r_sample <= sample_sat;
        end
        if (r_state == lttt_pkg::ST_LREAD) begin
            r_p_old <= MulW'(r_lrd) * MulW'(wgt_inv);
            r_p_new <= MulW'(r_sample) * MulW'(wgt);
        end
        r_ev  <= n_ev;
        r_upd <= n_upd;
        r_ulk <= n_ulk;
        r_tt  <= n_tt;
        if (out_ld) begin
            r_out_ev  <= r_ev;
            r_out_upd <= r_upd;
            r_out_ulk <= r_ulk;
            r_out_tt  <= r_tt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_tt, r_out_ulk};
    assign o_m_axis_tuser  = {r_out_upd, r_out_ev};

    // a fold always follows a link table read
    a_fold_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lttt_pkg::ST_FOLD) |-> ($past(r_state) == lttt_pkg::ST_LREAD))
        else $error("fold without link read");

    // an accepted item goes to the vehicle table decision next
    a_accept_to_vread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state == lttt_pkg::ST_VREAD))
        else $error("accepted item not decoded");

    // updated is set exactly for loads and folds
    a_upd_matches_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[3] ==
            ((r_out_ev == lttt_pkg::EV_LOADED) || (r_out_ev == lttt_pkg::EV_FREED) ||
             (r_out_ev == lttt_pkg::EV_MOVED))))
        else $error("updated flag does not match event");

    // a result without an update carries zero link and time
    a_no_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[3]) |-> (o_m_axis_tdata == '0))
        else $error("stale link or time on result without update");

endmodule

`default_nettype wire

### test/lttt_result_checker.sv
`timescale 1ns / 100ps

module lttt_result_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    input  wire logic                          i_s_tready,
    // vehicle_id, link_id, tick, load_value, zeros above
    input  wire logic [lttt_pkg::S_DATA_W-1:0] i_s_tdata,
    // op
    input  wire logic [0:0]                    i_s_tuser,
    input  wire logic                          i_s_tlast,
    input  wire logic                          i_m_tvalid,
    input  wire logic                          i_m_tready,
    // updated_link, travel_time
    input  wire logic [lttt_pkg::M_DATA_W-1:0] i_m_tdata,
    // event_res, updated
    input  wire logic [lttt_pkg::M_USER_W-1:0] i_m_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [lttt_pkg::CFG_W-1:0]    i_cfg_data,
    output int                                 o_pending,
    output int                                 o_fail_count
);
    import lttt_pkg::*;

    typedef struct packed {
        t_event             ev;
        logic               updated;
        logic [LID_W-1:0]   link;
        logic [TIME_W-1:0]  tt;
    } t_travel_result;

    logic              veh_active [VEHICLES_DEF];
    logic [LID_W-1:0]  veh_link   [VEHICLES_DEF];
    logic [TICK_W-1:0] veh_entry  [VEHICLES_DEF];
    logic [TIME_W-1:0] link_time  [LINKS_DEF];
    logic [UNIT_W-1:0] tick_scale = TICK_SCALE_RST;
    logic [WGT_W-1:0]  ema_weight = EMA_WEIGHT_RST;
    t_travel_result    results_due [$];
    int                fails = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // exponential average of the old time and ticks * tick scale
    function automatic logic [TIME_W-1:0] blend_sample(input logic [TIME_W-1:0] old,
                                                       input logic [TICK_W-1:0] ticks);
        logic [47:0] sample;
        logic [47:0] w;
        logic [47:0] acc;
        sample = 48'(ticks) * 48'(tick_scale);
        if (sample > 48'hFFFF_FFFF)
            sample = 48'hFFFF_FFFF;
        w = (ema_weight > WEIGHT_ONE) ? 48'(WEIGHT_ONE) : 48'(ema_weight);
        acc = 48'(old) * (48'd256 - w) + w * sample + 48'(ROUND_HALF);
        return acc[TIME_W+7:8];
    endfunction

    // applies one item to the tables and returns the result it causes
    function automatic t_travel_result track_item(input logic [S_DATA_W-1:0] d,
                                                  input t_op op, input logic fin);
        logic [VID_W-1:0]  vid;
        logic [LID_W-1:0]  lk;
        logic [TICK_W-1:0] tk;
        logic [TIME_W-1:0] lv;
        t_travel_result    r;
        vid = d[VID_W-1:0];
        lk  = d[VID_W +: LID_W];
        tk  = d[VID_W+LID_W +: TICK_W];
        lv  = d[VID_W+LID_W+TICK_W +: TIME_W];
        r.ev      = EV_ERROR;
        r.updated = 1'b0;
        r.link    = '0;
        r.tt      = '0;
        if (op == OP_LOAD) begin
            link_time[lk] = lv;
            r.ev      = EV_LOADED;
            r.updated = 1'b1;
            r.link    = lk;
            r.tt      = lv;
        end else if (!veh_active[vid]) begin
            veh_active[vid] = 1'b1;
            veh_link[vid]   = lk;
            veh_entry[vid]  = tk;
            r.ev            = EV_REGISTERED;
        end else if (fin || veh_link[vid] != lk) begin
            // sample always goes to the link the vehicle was on
            r.link    = veh_link[vid];
            r.tt      = blend_sample(link_time[r.link], tk - veh_entry[vid]);
            r.updated = 1'b1;
            link_time[r.link] = r.tt;
            if (fin) begin
                veh_active[vid] = 1'b0;
                r.ev            = EV_FREED;
            end else begin
                veh_link[vid]  = lk;
                veh_entry[vid] = tk;
                r.ev           = EV_MOVED;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_travel_result got;
        t_travel_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < VEHICLES_DEF; i++)
                veh_active[i] = 1'b0;
            tick_scale = TICK_SCALE_RST;
            ema_weight = EMA_WEIGHT_RST;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_TICK_SCALE)
                    tick_scale = i_cfg_data[UNIT_W-1:0];
                else
                    ema_weight = i_cfg_data[WGT_W-1:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                got.ev      = t_event'(i_m_tuser[2:0]);
                got.updated = i_m_tuser[3];
                got.link    = i_m_tdata[LID_W-1:0];
                got.tt      = i_m_tdata[LID_W +: TIME_W];
                if (results_due.size() == 0) begin
                    $error("result item with no item outstanding");
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (got.ev != want.ev) begin
                        $error("event_res: expected %0d, got %0d", want.ev, got.ev);
                        fails++;
                    end
                    if (got.updated != want.updated) begin
                        $error("updated: expected %0d, got %0d", want.updated, got.updated);
                        fails++;
                    end
                    if (got.link != want.link) begin
                        $error("updated_link: expected %0d, got %0d", want.link, got.link);
                        fails++;
                    end
                    if (got.tt != want.tt) begin
                        $error("travel_time: expected %h, got %h", want.tt, got.tt);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(track_item(i_s_tdata, t_op'(i_s_tuser[0]), i_s_tlast));
        end
        o_pending    = results_due.size();
        o_fail_count = fails;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lttt_pkg::*;

    // the slowest correct run, clearing pass included, ends well within RUN_LIMIT
    localparam int RUN_LIMIT = 200000;
    localparam int FLEET_SIZE = 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // vehicle_id, link_id, tick, load_value, zeros above
    logic [S_DATA_W-1:0] s_tdata = '0;
    // op
    logic [0:0]          s_tuser = '0;
    // finished
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // updated_link, travel_time
    logic [M_DATA_W-1:0] m_tdata;
    // event_res, updated
    logic [M_USER_W-1:0] m_tuser;
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_idx = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    int                  pending;
    int                  fail_count;
    int unsigned         cycle_count = 0;

    // no random gaps on either side while this is set
    logic                steady = 1'b0;
    // links that hold a loaded time; observe items only name these, so a
    // vehicle never folds its sample into a link that was never loaded
    logic [LID_W-1:0]    loaded_links [$];
    logic                link_loaded [LINKS_DEF];
    // small set of vehicle ids so that the same vehicles keep coming back
    logic [VID_W-1:0]    fleet [FLEET_SIZE];
    logic [TICK_W-1:0]   tick_now = '0;

    always #1 clk = ~clk;

    link_travel_time_tracker dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    lttt_result_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // result side stalls about 11 times in a hundred, never while steady is set
    always @(negedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 11);

    // hands one item over, with random idle cycles in front of it;
    // returns on the falling edge after the item was taken
    task automatic send_item(input t_op op, input logic [VID_W-1:0] vid,
                             input logic [LID_W-1:0] lk, input logic fin,
                             input logic [TICK_W-1:0] tk, input logic [TIME_W-1:0] lv);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= fin;
        s_tdata  <= S_DATA_W'({lv, tk, lk, vid});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (op == OP_LOAD && !link_loaded[lk]) begin
            link_loaded[lk] = 1'b1;
            loaded_links.push_back(lk);
        end
    endtask

    // stop sending and wait until every result item is back
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    // mostly well-formed vehicle traffic over the fleet, some loads,
    // and a few observe items for arbitrary vehicles at arbitrary ticks
    task automatic random_item;
        int unsigned       pick;
        logic [LID_W-1:0]  lk;
        logic              fin;
        logic [TIME_W-1:0] lv;
        pick = $urandom_range(0, 99);
        lv   = $urandom;
        if ($urandom_range(0, 15) == 0)
            lv = ($urandom_range(0, 1) != 0) ? '1 : '0;
        // mostly short hops, now and then a long one so ticks wrap
        tick_now += TICK_W'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 4000 : 150));
        if (pick < 15) begin
            send_item(OP_LOAD, VID_W'($urandom), LID_W'($urandom), 1'($urandom),
                      TICK_W'($urandom), lv);
        end else begin
            // the first few loaded links are hot, so vehicles often stay put
            if ($urandom_range(0, 2) == 0)
                lk = loaded_links[$urandom_range(0, 3)];
            else
                lk = loaded_links[$urandom_range(0, loaded_links.size() - 1)];
            fin = ($urandom_range(0, 99) < 22);
            if (pick >= 95)
                send_item(OP_OBSERVE, VID_W'($urandom), lk, fin, TICK_W'($urandom), lv);
            else
                send_item(OP_OBSERVE, fleet[$urandom_range(0, FLEET_SIZE - 1)], lk, fin,
                          tick_now, lv);
        end
    endtask

    // new register setting once the block is idle, then a batch of items
    task automatic run_phase(input logic [UNIT_W-1:0] unit, input logic [WGT_W-1:0] weight,
                             input int count);
        drain;
        write_reg(CFG_TICK_SCALE, CFG_W'(unit));
        write_reg(CFG_EMA_WEIGHT, CFG_W'(weight));
        cfg_we <= 1'b0;
        repeat (count)
            random_item();
    endtask

    // run limit
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        for (int i = 0; i < LINKS_DEF; i++)
            link_loaded[i] = 1'b0;
        fleet[0] = '0;
        fleet[1] = '1;
        for (int i = 2; i < FLEET_SIZE; i++)
            fleet[i] = VID_W'($urandom_range(0, VEHICLES_DEF - 1));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed part, reset register values
        // loads at the extremes of link and time
        send_item(OP_LOAD, 10'd0, 8'd255, 1'b0, 16'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 10'd1023, 8'd0, 1'b1, 16'hFFFF, 32'd0);
        send_item(OP_LOAD, 10'd5, 8'd1, 1'b0, 16'd7, 32'h0000_0A00);
        send_item(OP_LOAD, 10'd6, 8'd170, 1'b0, 16'd7, 32'h5555_5555);
        // first sight of vehicle 0
        send_item(OP_OBSERVE, 10'd0, 8'd0, 1'b0, 16'd0, 32'd0);
        // same link and not finished: error, no change
        send_item(OP_OBSERVE, 10'd0, 8'd0, 1'b0, 16'd40, 32'd0);
        // moves on, sample folded into link 0
        send_item(OP_OBSERVE, 10'd0, 8'd255, 1'b0, 16'd100, 32'd0);
        // registered just before the tick wraps, finished just after
        send_item(OP_OBSERVE, 10'd1023, 8'd255, 1'b0, 16'hFFF0, 32'hFFFF_FFFF);
        send_item(OP_OBSERVE, 10'd1023, 8'd1, 1'b1, 16'd20, 32'hFFFF_FFFF);
        // finished and on another link at once: freed, sample to the old link
        send_item(OP_OBSERVE, 10'd0, 8'd1, 1'b1, 16'd300, 32'd0);
        // freed vehicle comes back, then finishes with no time elapsed
        send_item(OP_OBSERVE, 10'd0, 8'd170, 1'b0, 16'd300, 32'd0);
        send_item(OP_OBSERVE, 10'd0, 8'd170, 1'b1, 16'd300, 32'd0);
        // unknown vehicle with finished set still just registers
        send_item(OP_OBSERVE, 10'd512, 8'd1, 1'b1, 16'd1, 32'd0);
        // longest possible stay before moving
        send_item(OP_OBSERVE, 10'd512, 8'd170, 1'b0, 16'd0, 32'd0);

        // random part over several register settings, extremes included
        run_phase(16'd0, 9'd0, 135);
        run_phase(16'd65535, 9'd256, 135);
        steady = 1'b1;
        run_phase(16'd65535, 9'd511, 135);
        steady = 1'b0;
        run_phase(16'd1, 9'd1, 135);
        run_phase(16'($urandom), 9'($urandom), 135);
        run_phase(16'd384, 9'd200, 135);

        drain;
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### files.f
hw/rtl/lttt_pkg.sv
hw/rtl/link_travel_time_tracker.sv
test/lttt_result_checker.sv
test/tb_top.sv
